// ===== rtl/core/emb_pkg.sv =====
// Shared types and constants for the 3x3 emboss filter.
package emb_pkg;

    localparam int PIX_W         = 8;
    localparam int DEF_MAX_WIDTH = 2048;
    localparam int CFG_W_BITS    = 12;
    localparam int CFG_H_BITS    = 16;
    localparam int RESET_WIDTH   = 640;
    localparam int RESET_HEIGHT  = 480;
    localparam int MIN_DIM       = 3;
    localparam int SUM_W         = 11;
    localparam int OUT_SHIFT     = 3;
    localparam logic [SUM_W-1:0] BIAS = 11'd765;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // line store entry: row r-1 in the upper byte, row r-2 in the lower byte
    typedef struct packed {
        t_pix up1;
        t_pix up2;
    } t_line_word;

    // kernel {-1,-1,0; -1,0,1; 0,1,1} plus bias, shifted right by three
    function automatic t_pix emboss(input t_pix w0, input t_pix w1, input t_pix w2,
                                    input t_pix up1, input t_pix w5, input t_pix cur);
        logic [SUM_W-1:0] pos;
        logic [SUM_W-1:0] neg;
        logic [SUM_W-1:0] diff;
        pos  = SUM_W'(up1) + SUM_W'(w5) + SUM_W'(cur) + BIAS;
        neg  = SUM_W'(w0) + SUM_W'(w1) + SUM_W'(w2);
        diff = pos - neg;
        return diff[OUT_SHIFT +: PIX_W];
    endfunction

endpackage

// ===== rtl/core/emb_tap_cell.sv =====
// One window tap: a pixel register that passes its word to the next tap.
module emb_tap_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  emb_pkg::t_pix i_pix,
    output emb_pkg::t_pix o_pix
);
    import emb_pkg::*;

    t_pix r_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== rtl/core/emb_line_buf.sv =====
// Dual line store: one write port, one registered read port.
module emb_line_buf #(
    parameter int DEPTH = emb_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  emb_pkg::t_line_word i_wdata,
    input  logic                i_re,
    input  logic [AW-1:0]       i_raddr,
    output emb_pkg::t_line_word o_rdata
);
    import emb_pkg::*;

    t_line_word r_mem [DEPTH];
    t_line_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/emboss_3x3_filter.sv =====
// Streaming 3x3 emboss filter: top level with counters, window chain and APB registers.
// An accepted word is registered in stage one; its result is written to the output
// register as it leaves stage one, when the output register is free.
// Throughput: one pixel per cycle while the output is not stalled; the line store is
// read when a pixel is accepted and written from stage one through a separate port.
// Reset: counters, window taps and valid flags clear and the size registers load
// 640x480; the line stores are then swept to zero, and no pixel is accepted meanwhile.
module emboss_3x3_filter #(
    parameter int MAX_WIDTH = emb_pkg::DEF_MAX_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  emb_pkg::t_pix       i_pixel_in,
    output logic                o_valid,
    input  logic                i_ready,
    output emb_pkg::t_pix       o_pixel_out,
    output logic                o_frame_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import emb_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = (CFG_W_BITS > $clog2(MAX_WIDTH + 1)) ? CFG_W_BITS
                                                              : $clog2(MAX_WIDTH + 1);
    localparam int HW  = CFG_H_BITS + 1;
    localparam logic [WW-1:0] W_MIN = WW'(MIN_DIM);
    localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);
    localparam logic [CW-1:0] CLR_LAST = CW'(MAX_WIDTH - 1);

    // configuration
    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic                  cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W_BITS'(RESET_WIDTH);
            r_height <= CFG_H_BITS'(RESET_HEIGHT);
        end else if (cfg_we) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_H_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        if (WW'(r_width) < W_MIN) begin
            w_eff = W_MIN;
        end else if (WW'(r_width) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = WW'(r_width);
        end
        h_eff = (r_height < CFG_H_BITS'(MIN_DIM)) ? HW'(MIN_DIM) : HW'(r_height);
    end

    // line store clearing sweep
    logic          r_clr;
    logic [CW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr <= 1'b0;
            end
        end
    end

    // pipeline control
    logic          r_s1_valid;
    logic          r_s1_res;
    logic          r_s1_last;
    t_pix          r_s1_pix;
    logic [CW-1:0] r_s1_addr;
    logic          r_out_valid;
    t_pix          r_out_pix;
    logic          r_out_last;
    logic          s1_adv;
    logic          in_acc;

    assign s1_adv  = r_s1_valid && (!r_s1_res || !r_out_valid || i_ready);
    assign o_ready = !r_clr && (!r_s1_valid || s1_adv);
    assign in_acc  = i_valid && o_ready;

    // counters
    logic [CW-1:0] r_col;
    logic [CW-1:0] n_col;
    logic [CFG_H_BITS-1:0] r_row;
    logic [CFG_H_BITS-1:0] n_row;
    logic          last_col;
    logic          last_row;
    logic          has_res;

    always_comb begin
        last_col = (WW'(r_col) + WW'(1)) >= w_eff;
        last_row = (HW'(r_row) + HW'(1)) >= h_eff;
        has_res  = (r_row >= CFG_H_BITS'(2)) && (r_col >= CW'(2));
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res  <= has_res;
            r_s1_last <= last_col && last_row;
            r_s1_pix  <= i_pixel_in;
            r_s1_addr <= r_col;
        end
    end

    // line stores
    t_line_word rd_word;
    t_line_word wr_word;
    logic       mem_we;
    logic [CW-1:0] mem_waddr;

    always_comb begin
        if (r_clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            wr_word   = '0;
        end else begin
            mem_we      = s1_adv;
            mem_waddr   = r_s1_addr;
            wr_word.up1 = r_s1_pix;
            wr_word.up2 = rd_word.up1;
        end
    end

    emb_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (wr_word),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rd_word)
    );

    // window taps: rows r-2 and r-1 two deep, row r one deep
    t_pix w0, w1, w2, w3, w5;

    emb_tap_cell u_tap1 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(s1_adv),
                         .i_pix(rd_word.up2), .o_pix(w1));
    emb_tap_cell u_tap0 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(s1_adv),
                         .i_pix(w1), .o_pix(w0));
    emb_tap_cell u_tap3 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(s1_adv),
                         .i_pix(rd_word.up1), .o_pix(w3));
    emb_tap_cell u_tap2 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(s1_adv),
                         .i_pix(w3), .o_pix(w2));
    emb_tap_cell u_tap5 (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_shift(s1_adv),
                         .i_pix(r_s1_pix), .o_pix(w5));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_res) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_res) begin
            r_out_pix  <= emboss(w0, w1, w2, rd_word.up1, w5, r_s1_pix);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_out  = r_out_pix;
    assign o_frame_last = r_out_last;

    a_no_accept_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready && !r_s1_valid)
        else $error("pixel accepted during line store clear");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted word lost before stage one");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_out <= t_pix'(191))
        else $error("emboss result out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_res && r_out_valid && !i_ready) |-> !s1_adv)
        else $error("stage one overwrote a pending result");

endmodule
